/* rtl/core/per_slot_serial_dispatcher_defines.svh */
// Assertion macros shared by the dispatcher RTL.
`ifndef PER_SLOT_SERIAL_DISPATCHER_DEFINES_SVH
`define PER_SLOT_SERIAL_DISPATCHER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PSSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PSSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pssd_pkg.sv */
// Types, constants and helpers of the per-slot serial dispatcher.
package pssd_pkg;

    localparam int NUM_SLOTS   = 64;
    localparam int QUEUE_DEPTH = 32;
    localparam int TAG_BITS    = 16;

    localparam int GEN_W      = 8;
    localparam int SLOT_AW    = $clog2(NUM_SLOTS);
    localparam int PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QADDR_W    = $clog2(NUM_SLOTS * QUEUE_DEPTH);
    localparam int QENT_W     = GEN_W + TAG_BITS;

    // Port field widths
    localparam int MODE_W     = 2;
    localparam int SLOT_W     = 6;
    localparam int TAG_W      = 16;
    localparam int STATUS_W   = 3;
    localparam int PEND_W     = 7;
    localparam int DEPTH_W    = 6;
    localparam int ASLOTS_W   = 7;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam int SLOTS_CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int CMP_W       = ((SLOTS_CNT_W > ASLOTS_W) ? SLOTS_CNT_W : ASLOTS_W) + 1;

    localparam logic [PEND_W-1:0]   PEND_MAX     = PEND_W'(127);
    localparam logic [ASLOTS_W-1:0] ASLOTS_RESET = ASLOTS_W'(64);

    // Register indexes on the configuration port
    localparam logic [0:0] REG_ENABLE       = 1'b0;
    localparam logic [0:0] REG_ACTIVE_SLOTS = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MD_SUBMIT = 2'd0,
        MD_DONE   = 2'd1,
        MD_CLOSE  = 2'd2,
        MD_OPEN   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DISPATCHED  = 3'd0,
        ST_QUEUED      = 3'd1,
        ST_QUEUED_DROP = 3'd2,
        ST_IDLE        = 3'd3,
        ST_STALE       = 3'd4,
        ST_CLOSED      = 3'd5,
        ST_OPENED      = 3'd6,
        ST_REJECTED    = 3'd7
    } t_status;

    typedef struct packed {
        logic             busy;
        logic [GEN_W-1:0] gen;
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
        logic [CNT_W-1:0] count;
    } t_slot_entry;

    localparam int SLOT_ENT_W = $bits(t_slot_entry);

    typedef struct packed {
        logic [GEN_W-1:0]    gen;
        logic [TAG_BITS-1:0] tag;
    } t_q_entry;

    function automatic logic [PTR_W-1:0] nxt_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PEND_W-1:0] pend_up(input logic [PEND_W-1:0] v);
        return (v < PEND_MAX) ? v + PEND_W'(1) : v;
    endfunction

    function automatic logic [PEND_W-1:0] pend_down(input logic [PEND_W-1:0] v);
        return (v != '0) ? v - PEND_W'(1) : v;
    endfunction

endpackage

/* rtl/core/pssd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module pssd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/per_slot_serial_dispatcher.sv */
// Top level of the per-slot serial dispatcher: control, slot state and queue memories.
//
//  channel   direction  handshake                         payload
//  -------   ---------  --------------------------------  ---------------------------------
//  event     in         i_in_valid / o_in_ready           i_mode, i_slot, i_work_tag
//  result    out        o_out_valid / i_out_ready         o_status, o_out_slot,
//                                                         o_dispatch_tag, o_pending,
//                                                         o_queue_depth
//  config    in         psel, penable, pwrite, pready     paddr, pwdata, prdata
//
// An item first reads the slot's state memory, then updates it and writes the result
// register. A done event that pops a queued entry adds the S_POP state, after the
// queue memory read. The next item enters on the cycle its predecessor commits.
// Reset is synchronous; per-slot valid flops make every slot read as zero after reset,
// so no clearing pass is needed. A stalled result register holds the commit and the input.
`include "per_slot_serial_dispatcher_defines.svh"

module per_slot_serial_dispatcher (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [pssd_pkg::MODE_W-1:0]  i_mode,
    input  logic [pssd_pkg::SLOT_W-1:0]  i_slot,
    input  logic [pssd_pkg::TAG_W-1:0]   i_work_tag,

    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [pssd_pkg::STATUS_W-1:0] o_status,
    output logic [pssd_pkg::SLOT_W-1:0]  o_out_slot,
    output logic [pssd_pkg::TAG_W-1:0]   o_dispatch_tag,
    output logic [pssd_pkg::PEND_W-1:0]  o_pending,
    output logic [pssd_pkg::DEPTH_W-1:0] o_queue_depth,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pssd_pkg::APB_AW-1:0]  paddr,
    input  logic [pssd_pkg::APB_DW-1:0]  pwdata,
    output logic [pssd_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_POP
    } t_state;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic                               r_enable;
    logic [pssd_pkg::ASLOTS_W-1:0]      r_active_slots;
    logic                               w_cfg_wr;
    logic [0:0]                         w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[2:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable       <= 1'b0;
            r_active_slots <= pssd_pkg::ASLOTS_RESET;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                pssd_pkg::REG_ENABLE:       r_enable       <= pwdata[0];
                pssd_pkg::REG_ACTIVE_SLOTS: r_active_slots <= pwdata[pssd_pkg::ASLOTS_W-1:0];
                default:                    r_enable       <= r_enable;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            pssd_pkg::REG_ENABLE:       prdata = pssd_pkg::APB_DW'(r_enable);
            pssd_pkg::REG_ACTIVE_SLOTS: prdata = pssd_pkg::APB_DW'(r_active_slots);
            default:                    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Control and item registers
    // ---------------------------------------------------------------------
    t_state                             r_state;
    pssd_pkg::t_mode                    r_mode;
    logic [pssd_pkg::SLOT_W-1:0]        r_slot;
    logic [pssd_pkg::TAG_BITS-1:0]      r_tag;
    logic [pssd_pkg::SLOT_AW-1:0]       r_idx;
    logic [pssd_pkg::PEND_W-1:0]        r_pending;
    logic [pssd_pkg::NUM_SLOTS-1:0]     r_valid;
    logic                               r_fwd;
    pssd_pkg::t_slot_entry              r_fwd_data;

    logic                               r_out_valid;
    pssd_pkg::t_status                  r_out_status;
    logic [pssd_pkg::SLOT_W-1:0]        r_out_slot;
    logic [pssd_pkg::TAG_BITS-1:0]      r_out_tag;
    logic [pssd_pkg::PEND_W-1:0]        r_out_pending;
    logic [pssd_pkg::CNT_W-1:0]         r_out_depth;

    // Memory ports
    logic [pssd_pkg::SLOT_ENT_W-1:0]    w_slot_rdata;
    logic [pssd_pkg::QENT_W-1:0]        w_q_rdata;
    logic                               w_slot_we;
    logic                               w_q_we;
    logic                               w_q_re;
    logic [pssd_pkg::QADDR_W-1:0]       w_q_waddr;
    logic [pssd_pkg::QADDR_W-1:0]       w_q_raddr;
    pssd_pkg::t_q_entry                 w_q_wdata;

    // Event evaluation
    pssd_pkg::t_slot_entry              w_ent;
    pssd_pkg::t_slot_entry              n_ent;
    pssd_pkg::t_q_entry                 w_qe;
    logic                               w_reject;
    logic                               w_in_range;
    logic                               w_need_pop;
    logic                               w_slot_wr;
    logic                               w_q_wr;
    logic                               w_out_free;
    logic                               w_commit;
    logic                               w_accept;
    logic [pssd_pkg::PEND_W-1:0]        n_pending;
    pssd_pkg::t_status                  n_status;
    logic [pssd_pkg::TAG_BITS-1:0]      n_tag;
    logic [pssd_pkg::CNT_W-1:0]         n_depth;
    logic [pssd_pkg::PTR_W-1:0]         w_qptr;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) || w_commit;
    assign w_accept   = i_in_valid && o_in_ready;

    // Slots at or above min(active_slots, NUM_SLOTS) are out of range
    assign w_in_range = (pssd_pkg::CMP_W'(r_slot) < pssd_pkg::CMP_W'(r_active_slots)) &&
                        (pssd_pkg::CMP_W'(r_slot) < pssd_pkg::CMP_W'(pssd_pkg::NUM_SLOTS));
    assign w_reject   = !w_in_range || ((r_mode == pssd_pkg::MD_SUBMIT) && !r_enable);

    always_comb begin
        // Forwarded data wins over the memory; a never-written slot reads as zero
        if (r_fwd) begin
            w_ent = r_fwd_data;
        end else if (r_valid[r_idx]) begin
            w_ent = pssd_pkg::t_slot_entry'(w_slot_rdata);
        end else begin
            w_ent = '0;
        end
        w_qe       = pssd_pkg::t_q_entry'(w_q_rdata);

        n_ent      = w_ent;
        n_pending  = r_pending;
        n_status   = pssd_pkg::ST_REJECTED;
        n_tag      = '0;
        n_depth    = '0;
        w_slot_wr  = 1'b0;
        w_q_wr     = 1'b0;
        w_q_re     = 1'b0;
        w_need_pop = 1'b0;
        w_qptr     = w_ent.tail;

        if (r_state == S_READ && !w_reject) begin
            case (r_mode)
                pssd_pkg::MD_SUBMIT: begin
                    w_slot_wr = 1'b1;
                    if (!w_ent.busy) begin
                        n_ent.busy = 1'b1;
                        n_pending  = pssd_pkg::pend_up(r_pending);
                        n_tag      = r_tag;
                        n_status   = pssd_pkg::ST_DISPATCHED;
                        n_depth    = w_ent.count;
                    end else begin
                        n_status = pssd_pkg::ST_QUEUED;
                        // Full queue: drop the oldest entry before the push
                        if (w_ent.count >= pssd_pkg::CNT_W'(pssd_pkg::QUEUE_DEPTH)) begin
                            n_ent.head  = pssd_pkg::nxt_ptr(w_ent.head);
                            n_ent.count = w_ent.count - pssd_pkg::CNT_W'(1);
                            n_status    = pssd_pkg::ST_QUEUED_DROP;
                        end
                        w_q_wr      = 1'b1;
                        n_ent.tail  = pssd_pkg::nxt_ptr(w_ent.tail);
                        n_ent.count = n_ent.count + pssd_pkg::CNT_W'(1);
                        n_depth     = n_ent.count;
                    end
                end
                pssd_pkg::MD_DONE: begin
                    n_status = pssd_pkg::ST_IDLE;
                    n_depth  = w_ent.count;
                    if (w_ent.busy) begin
                        if (w_ent.count == '0) begin
                            w_slot_wr  = 1'b1;
                            n_ent.busy = 1'b0;
                            n_pending  = pssd_pkg::pend_down(r_pending);
                        end else begin
                            // Fetch the head entry; finish in the pop cycle
                            w_need_pop = 1'b1;
                            w_q_re     = 1'b1;
                            w_qptr     = w_ent.head;
                        end
                    end
                end
                pssd_pkg::MD_CLOSE: begin
                    w_slot_wr   = 1'b1;
                    n_ent.head  = '0;
                    n_ent.tail  = '0;
                    n_ent.count = '0;
                    n_ent.gen   = w_ent.gen + pssd_pkg::GEN_W'(1);
                    n_status    = pssd_pkg::ST_CLOSED;
                end
                pssd_pkg::MD_OPEN: begin
                    w_slot_wr   = 1'b1;
                    n_ent.head  = '0;
                    n_ent.tail  = '0;
                    n_ent.count = '0;
                    n_status    = pssd_pkg::ST_OPENED;
                end
                default: begin
                    n_status = pssd_pkg::ST_REJECTED;
                end
            endcase
        end else if (r_state == S_POP) begin
            w_slot_wr = 1'b1;
            if (w_qe.gen != w_ent.gen) begin
                // Stale generation: discard the whole queue
                n_ent.busy  = 1'b0;
                n_ent.head  = '0;
                n_ent.tail  = '0;
                n_ent.count = '0;
                n_pending   = pssd_pkg::pend_down(r_pending);
                n_status    = pssd_pkg::ST_STALE;
            end else begin
                n_ent.head  = pssd_pkg::nxt_ptr(w_ent.head);
                n_ent.count = w_ent.count - pssd_pkg::CNT_W'(1);
                n_pending   = pssd_pkg::pend_up(pssd_pkg::pend_down(r_pending));
                n_tag       = w_qe.tag;
                n_status    = pssd_pkg::ST_DISPATCHED;
                n_depth     = w_ent.count - pssd_pkg::CNT_W'(1);
            end
        end
    end

    assign w_commit  = (((r_state == S_READ) && !w_need_pop) || (r_state == S_POP)) &&
                       w_out_free;
    assign w_slot_we = w_slot_wr && w_commit;
    assign w_q_we    = w_q_wr && w_commit;

    assign w_q_wdata = '{gen: w_ent.gen, tag: r_tag};
    assign w_q_waddr = pssd_pkg::QADDR_W'(r_idx) * pssd_pkg::QADDR_W'(pssd_pkg::QUEUE_DEPTH) +
                       pssd_pkg::QADDR_W'(w_qptr);
    assign w_q_raddr = w_q_waddr;

    // ---------------------------------------------------------------------
    // State machine, item capture and result register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pending   <= '0;
            r_valid     <= '0;
            r_fwd       <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (w_need_pop) begin
                        r_state <= S_POP;
                    end else if (w_commit) begin
                        r_state <= w_accept ? S_READ : S_IDLE;
                    end
                end
                S_POP: begin
                    if (w_commit) begin
                        r_state <= w_accept ? S_READ : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Load a new result, or drain the one just taken
            if (w_commit) begin
                r_out_valid <= 1'b1;
                r_pending   <= n_pending;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_slot_we) begin
                r_valid[r_idx] <= 1'b1;
            end

            // Forward a same-slot write that lands on the edge of the next read
            if (w_accept) begin
                r_fwd <= w_slot_we && (r_idx == pssd_pkg::SLOT_AW'(i_slot));
            end
        end

        // Payload registers
        if (w_accept) begin
            r_mode     <= pssd_pkg::t_mode'(i_mode);
            r_slot     <= i_slot;
            r_idx      <= pssd_pkg::SLOT_AW'(i_slot);
            r_tag      <= pssd_pkg::TAG_BITS'(i_work_tag);
            r_fwd_data <= n_ent;
        end
        if (w_commit) begin
            r_out_status  <= n_status;
            r_out_slot    <= r_slot;
            r_out_tag     <= n_tag;
            r_out_pending <= n_pending;
            r_out_depth   <= n_depth;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_out_slot     = r_out_slot;
    assign o_dispatch_tag = pssd_pkg::TAG_W'(r_out_tag);
    assign o_pending      = r_out_pending;
    assign o_queue_depth  = pssd_pkg::DEPTH_W'(r_out_depth);

    // ---------------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------------
    pssd_ram #(
        .WIDTH (pssd_pkg::SLOT_ENT_W),
        .DEPTH (pssd_pkg::NUM_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_slot_we),
        .i_waddr (r_idx),
        .i_wdata (n_ent),
        .i_re    (w_accept),
        .i_raddr (pssd_pkg::SLOT_AW'(i_slot)),
        .o_rdata (w_slot_rdata)
    );

    pssd_ram #(
        .WIDTH (pssd_pkg::QENT_W),
        .DEPTH (pssd_pkg::NUM_SLOTS * pssd_pkg::QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (w_q_waddr),
        .i_wdata (w_q_wdata),
        .i_re    (w_q_re),
        .i_raddr (w_q_raddr),
        .o_rdata (w_q_rdata)
    );

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `PSSD_ASSERT_NXT(a_pop_next, w_need_pop, r_state == S_POP, "pop state not entered")
    `PSSD_ASSERT_IMP(a_queue_wr_with_slot, w_q_we, w_slot_we, "queue write without slot update")
    `PSSD_ASSERT_NXT(a_pending_hold, !w_commit, $stable(r_pending), "pending moved without commit")

endmodule
